@@ rtl/zsm_pkg.sv @@
// Package for the zero-skipping 3x3 median filter: sizes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package zsm_pkg;
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam logic [11:0] WidthReset = 12'd640;
  localparam logic [15:0] HeightReset = 16'd480;

  typedef enum logic {
    CfgWidth = 1'b0,
    CfgHeight = 1'b1
  } cfg_idx_e;

  // Window columns handed from front end to sorter: three columns of three rows
  typedef struct packed {
    logic [2:0][2:0][7:0] win;
    logic last;
  } win_t;
endpackage
`default_nettype wire

@@ rtl/zsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module zsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ rtl/zsm_median.sv @@
// Pipelined zero-skipping median: rank sort over four register stages.
// Depends on zsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zsm_median (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire zsm_pkg::win_t data_i,
  output      logic          valid_o,
  output      logic [7:0]    value_o,
  output      logic          last_o
);
  // Stage 1: pairwise compares, count zeros. Stage 2: rank of each value.
  // Stage 3: place values by rank. Stage 4: pick.
  logic [8:0][7:0] vin;
  logic [8:0][7:0] v1_q, v2_q;
  logic [8:0][8:0] lt_d, lt_q;
  logic [8:0][3:0] rk_d, rk_q;
  logic [3:0] z1_d, z1_q, z2_q, z3_q;
  logic [8:0][7:0] srt_d, srt_q;
  logic [3:0] v_q;
  logic [3:0] l_q;
  logic [7:0] res_d, res_q;

  // Ties break on position so every value gets a distinct rank
  always_comb begin
    z1_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        vin[3*i+j] = data_i.win[i][j];
        z1_d = z1_d + 4'(data_i.win[i][j] == 8'd0);
      end
    end
    for (int a = 0; a < 9; a++) begin
      for (int b = 0; b < 9; b++) begin
        lt_d[a][b] = (b != a) && ((vin[b] < vin[a]) || ((vin[b] == vin[a]) && (b < a)));
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 9; a++) begin
      rk_d[a] = '0;
      for (int b = 0; b < 9; b++) begin
        rk_d[a] = rk_d[a] + 4'(lt_q[a][b]);
      end
    end
  end

  always_comb begin
    srt_d = '0;
    for (int a = 0; a < 9; a++) begin
      for (int r = 0; r < 9; r++) begin
        if (rk_q[a] == 4'(r)) srt_d[r] = v2_q[a];
      end
    end
  end

  always_comb begin
    logic [3:0] k;
    k = 4'((5'(z3_q) + 5'd8) >> 1);
    res_d = (z3_q == 4'd9) ? 8'd0 : srt_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q <= vin;
      lt_q <= lt_d;
      z1_q <= z1_d;
      v2_q <= v1_q;
      rk_q <= rk_d;
      z2_q <= z1_q;
      srt_q <= srt_d;
      z3_q <= z2_q;
      res_q <= res_d;
      l_q <= {l_q[2:0], data_i.last};
    end
  end

  assign valid_o = v_q[3];
  assign value_o = res_q;
  assign last_o = l_q[3];
endmodule
`default_nettype wire

@@ rtl/zero_skipping_median_3x3_top.sv @@
// Top level of the zero-skipping 3x3 median filter.
// An accepted item passes the stage A and stage B registers, the median pipeline and the output register.
// Throughput: one item per clock; stalls hold the whole pipeline; no transfer in
// during a configuration write. The line store is a 2-row RAM read ahead, so its data arrives with stage A.
// Reset clears position counters, window and valid bits; sizes go to 640x480.
// Depends on zsm_pkg, zsm_ram, zsm_median.
`timescale 1ns / 1ps
`default_nettype none
module zero_skipping_median_3x3_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  pixel_value_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  filtered_value_o,
  output      logic        frame_last_o
);
  localparam int unsigned AW = zsm_pkg::AddrW;

  logic [11:0] width_q;
  logic [15:0] height_q;
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  always_comb begin
    w_eff = (width_q < 12'd2) ? 12'd2 : width_q;
    if (w_eff > 12'(zsm_pkg::MaxWidth)) w_eff = 12'(zsm_pkg::MaxWidth);
    h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
  end

  // Pipeline enable: advance when the result slot is free or being taken
  logic en;
  logic med_valid;
  logic [7:0] med_value;
  logic med_last;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en && !cfg_we_i;

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // Stage A: position bookkeeping, RAM read issue
  logic [11:0] col_q;
  logic [16:0] row_q;
  logic [26:0] oidx_q;
  logic take;
  logic a_v_q, a_drain_q, a_r1_q;
  logic [7:0] a_pix_q;
  logic [11:0] a_col_q;
  logic [16:0] a_row_q;
  logic [15:0] a_h_q;
  assign take = acc && (req_type_i == (row_q >= {1'b0, h_eff}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= zsm_pkg::WidthReset;
      height_q <= zsm_pkg::HeightReset;
      col_q <= '0;
      row_q <= '0;
      a_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (zsm_pkg::cfg_idx_e'(cfg_idx_i))
          zsm_pkg::CfgWidth: width_q <= cfg_wdata_i[11:0];
          zsm_pkg::CfgHeight: height_q <= cfg_wdata_i;
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (take) begin
        if (row_q > {1'b0, h_eff}) begin
          // First drain past the bottom pushes out the final result: restart
          col_q <= '0;
          row_q <= '0;
        end else if (col_q + 12'd1 >= w_eff) begin
          col_q <= '0;
          row_q <= row_q + 17'd1;
        end else begin
          col_q <= col_q + 12'd1;
        end
      end
      if (en) a_v_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pix_q <= pixel_value_i;
      a_drain_q <= req_type_i;
      a_col_q <= col_q;
      a_row_q <= row_q;
      a_r1_q <= (row_q == 17'd1);
      a_h_q <= h_eff;
    end
  end

  // Line store: one RAM holds {row two above, row above} per column
  logic [15:0] ram_rd;
  logic [7:0] top, mid, bot;
  assign mid = ram_rd[7:0];
  assign top = a_r1_q ? mid : ram_rd[15:8];
  assign bot = a_drain_q ? mid : a_pix_q;
  zsm_ram #(.Width(16), .Depth(zsm_pkg::MaxWidth)) u_line (
    .clk_i  (clk_i),
    .we_i   (a_v_q && en),
    .waddr_i(a_col_q[AW-1:0]),
    .wdata_i({mid, bot}),
    .re_i   (en),
    .raddr_i(col_q[AW-1:0]),
    .rdata_o(ram_rd)
  );

  // Stage B: window shift and emit decision (matches per-item model step)
  logic [2:0][2:0][7:0] win_q;
  zsm_pkg::win_t b_d, b_q;
  logic b_v_d, b_v_q;
  logic [26:0] total;
  assign total = 27'(w_eff) * 27'(h_eff);
  always_comb begin
    logic [2:0][2:0][7:0] nw;
    b_d.win = win_q;
    b_v_d = 1'b0;
    nw = win_q;
    if (a_v_q && a_col_q == 12'd0 && a_row_q >= 17'd2) begin
      b_d.win = {win_q[2], win_q[2], win_q[1]};
      b_v_d = 1'b1;
    end
    if (a_v_q && a_row_q <= {1'b0, a_h_q}) begin
      nw[0] = win_q[1];
      nw[1] = win_q[2];
      nw[2] = {bot, mid, top};
      if (a_col_q >= 12'd1 && a_row_q >= 17'd1) begin
        b_d.win = {nw[2], nw[1], (a_col_q == 12'd1) ? nw[1] : nw[0]};
        b_v_d = 1'b1;
      end
    end
    b_d.last = (oidx_q == total - 27'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      b_v_q <= 1'b0;
      oidx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        oidx_q <= '0;
      end else if (en && b_v_d) begin
        oidx_q <= b_d.last ? 27'd0 : oidx_q + 27'd1;
      end
      if (en) begin
        b_v_q <= b_v_d;
        if (a_v_q && a_row_q <= {1'b0, a_h_q}) begin
          win_q <= {{bot, mid, top}, win_q[2], win_q[1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) b_q <= b_d;
  end

  zsm_median u_med (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(b_v_q),
    .data_i (b_q),
    .valid_o(med_valid),
    .value_o(med_value),
    .last_o (med_last)
  );

  // Output register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= med_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      filtered_value_o <= med_value;
      frame_last_o <= med_last;
    end
  end
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for zero_skipping_median_3x3_top.
// Runs directed and random frames against a built-in predictor of the filter.
// Depends on zsm_pkg and the filter RTL.
`timescale 1ns / 1ps
module tb_top;
  localparam int unsigned LineMax = 2048;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned WatchdogLimit = 40000;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } median_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  zsm_pkg::cfg_idx_e cfg_idx = zsm_pkg::CfgWidth;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic        req_type = 1'b0;
  logic [7:0]  pixel_value = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [7:0]  filtered_value_o;
  logic        frame_last_o;

  // Traffic shaping: percent of cycles the sender idles / the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  median_res_t median_q[$];

  // Predictor state, kept in step with the filter.
  logic [7:0]  rows_mem[2][LineMax];
  logic [7:0]  win[3][3];   // [column, 0 oldest][row, 0 top]
  int unsigned pos_col, pos_row, res_index;
  logic [11:0] width_reg;
  logic [15:0] height_reg;

  always #1 clk_i = ~clk_i;

  zero_skipping_median_3x3_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type),
    .pixel_value_i    (pixel_value),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .filtered_value_o (filtered_value_o),
    .frame_last_o     (frame_last_o)
  );

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  // Lower median of the non-zero values; zero when all nine are zero.
  function automatic logic [7:0] nonzero_median(input logic [7:0] a[3],
                                                input logic [7:0] b[3],
                                                input logic [7:0] c[3]);
    logic [7:0] v[9];
    logic [7:0] x;
    int zeros;
    int j;
    zeros = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = a[i];
      v[3+i] = b[i];
      v[6+i] = c[i];
    end
    for (int i = 1; i < 9; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    foreach (v[i]) if (v[i] == 0) zeros++;
    if (zeros == 9) return 8'd0;
    return v[(zeros + 8) / 2];
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > LineMax) return LineMax;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  task automatic restart_position();
    pos_col = 0;
    pos_row = 0;
    res_index = 0;
  endtask

  // Advance the predictor by one accepted item; queue any result it causes.
  task automatic advance_filter(input logic drain, input logic [7:0] pix);
    int unsigned w, h;
    logic emit;
    logic [7:0] value, top, mid, bot;
    median_res_t res;
    w = eff_width();
    h = eff_height();
    emit = 1'b0;
    value = '0;
    if (drain != (pos_row >= h)) return;
    if (pos_col >= w) begin
      restart_position();
      return;
    end
    // Right edge of the row two steps back, from the window before the shift.
    if (pos_col == 0 && pos_row >= 2) begin
      value = nonzero_median(win[1], win[2], win[2]);
      emit = 1'b1;
    end
    if (pos_row <= h) begin
      top = rows_mem[1][pos_col];
      mid = rows_mem[0][pos_col];
      bot = drain ? mid : pix;
      if (pos_row == 1) top = mid;
      rows_mem[1][pos_col] = mid;
      rows_mem[0][pos_col] = bot;
      win[0] = win[1];
      win[1] = win[2];
      win[2][0] = top;
      win[2][1] = mid;
      win[2][2] = bot;
      if (pos_col >= 1 && pos_row >= 1) begin
        if (pos_col == 1) value = nonzero_median(win[1], win[1], win[2]);
        else value = nonzero_median(win[0], win[1], win[2]);
        emit = 1'b1;
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (!emit) return;
    res.value = value;
    if (res_index == w * h - 1) begin
      res.last = 1'b1;
      restart_position();
    end else begin
      res.last = 1'b0;
      res_index = (res_index + 1) & 32'h7FF_FFFF;
    end
    median_q.push_back(res);
  endtask

  // Monitor: update the predictor on every transfer in, check every transfer out.
  always @(posedge clk_i) begin
    median_res_t exp_res;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_we) begin
        if (cfg_idx == zsm_pkg::CfgWidth) width_reg = cfg_wdata[11:0];
        else height_reg = cfg_wdata;
        restart_position();
      end
      if (in_valid && in_ready_o) begin
        moved = 1'b1;
        advance_filter(req_type, pixel_value);
      end
      if (out_valid_o && out_ready) begin
        moved = 1'b1;
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", filtered_value_o));
        end else begin
          exp_res = median_q.pop_front();
          if (filtered_value_o !== exp_res.value)
            report_mismatch($sformatf("filtered_value %0d, want %0d",
                                      filtered_value_o, exp_res.value));
          if (frame_last_o !== exp_res.last)
            report_mismatch($sformatf("frame_last %0b, want %0b",
                                      frame_last_o, exp_res.last));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("** zero_skipping_median_3x3_top: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: stall at random at the configured rate.
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one item and hold it until the transfer happens.
  task automatic send_item(input logic drain, input logic [7:0] pix);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= drain;
    pixel_value <= pix;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, then wait until every queued result has come out and the
  // pipeline has settled.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (median_q.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [15:0] w, input logic [15:0] h);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_idx <= zsm_pkg::CfgWidth;
    cfg_wdata <= w;
    @(negedge clk_i);
    cfg_idx <= zsm_pkg::CfgHeight;
    cfg_wdata <= h;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_pixel();
    // Pepper-heavy content so zero skipping gets exercised.
    return ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
  endfunction

  // Directed: field extremes, misplaced drain and pixel, extra drain.
  task automatic test_directed();
    write_size(16'd2, 16'd2);
    send_item(1'b1, 8'hFF);            // drain mid-frame: ignored
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd77);            // pixel while draining: ignored
    repeat (3) send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h5A);            // drain after final result: ignored
    write_size(16'd3, 16'd3);
    for (int i = 0; i < 9; i++)
      send_item(1'b0, (i % 3 == 0) ? 8'd255 : ((i % 3 == 1) ? 8'd0 : 8'd1));
    repeat (4) send_item(1'b1, 8'hAA);
    write_size(16'd4, 16'd2);          // all-zero frame
    repeat (8) send_item(1'b0, 8'd0);
    repeat (5) send_item(1'b1, 8'd0);
  endtask

  // Size extremes: clamped width, zero height, truncated width, tallest frame.
  task automatic test_size_extremes();
    write_size(16'd0, 16'd0);
    repeat (2) send_item(1'b0, rand_pixel());
    repeat (3) send_item(1'b1, 8'd0);
    write_size(16'hF003, 16'd2);       // upper data bits drop: width 3
    repeat (6) send_item(1'b0, rand_pixel());
    repeat (4) send_item(1'b1, 8'd0);
    write_size(16'd2, 16'hFFFF);       // tallest frame: abort part way
    repeat (60) send_item(1'b0, rand_pixel());
  endtask

  // Random frames with random content, with some noise items mixed in.
  task automatic test_random_frames(input int unsigned idle_pct,
                                    input int unsigned stall_pct,
                                    input int unsigned n_items);
    int unsigned sent, w, h;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(60, 2) : $urandom_range(12, 2);
      h = $urandom_range(6, 1);
      write_size(16'(w), 16'(h));
      for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(99) < 4) send_item(1'b1, 8'($urandom_range(255)));
        send_item(1'b0, rand_pixel());
      end
      for (int i = 0; i <= w; i++) begin
        if ($urandom_range(99) < 4) send_item(1'b0, 8'($urandom_range(255)));
        send_item(1'b1, 8'($urandom_range(255)));
      end
      if ($urandom_range(3) == 0) send_item(1'b1, 8'd0);
      sent += w * h;
    end
  endtask

  initial begin
    foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    restart_position();
    width_reg = zsm_pkg::WidthReset;
    height_reg = zsm_pkg::HeightReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_size_extremes();
    test_random_frames(0, 0, 330);
    test_random_frames(76, 0, 330);
    test_random_frames(0, 76, 330);
    test_random_frames(24, 24, 330);

    drain_pipeline();
    if (err_count == 0) begin
      $display("** zero_skipping_median_3x3_top: PASSED **");
    end else begin
      $display("** zero_skipping_median_3x3_top: FAILED **");
    end
    $finish;
  end
endmodule
